// ===== rtl/lts_pkg.sv =====
// ============================================================================
// lts_pkg
// Shared types, codes and character classes for the lisp token scanner.
// ============================================================================
package lts_pkg;

  // default text length limit
  localparam int MAX_TEXT_DFLT = 65536;

  // reset value of the start line register
  localparam logic [15:0] START_LINE_RST = 16'd1;

  // configuration port
  localparam int CFG_AW = 3;
  localparam logic REG_START_LINE = 1'b0;

  // result queue
  localparam int Q_DEPTH      = 8;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = $clog2(Q_DEPTH + 1);
  localparam int Q_ACCEPT_MAX = Q_DEPTH - 4;

  // result kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_ERROR = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;

  // token types
  localparam logic [2:0] TT_LPAREN = 3'd0;
  localparam logic [2:0] TT_RPAREN = 3'd1;
  localparam logic [2:0] TT_BOOL   = 3'd2;
  localparam logic [2:0] TT_INT    = 3'd3;
  localparam logic [2:0] TT_SYMBOL = 3'd4;
  localparam logic [2:0] TT_IF     = 3'd5;
  localparam logic [2:0] TT_LET    = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_SYM   = 3'd1;
  localparam logic [2:0] ERR_EOF_HASH  = 3'd2;
  localparam logic [2:0] ERR_BAD_BOOL  = 3'd3;
  localparam logic [2:0] ERR_BAD_TOKEN = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

  // commands
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // keyword prefix progress
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_I    = 3'd1;
  localparam logic [2:0] KW_IF   = 3'd2;
  localparam logic [2:0] KW_L    = 3'd3;
  localparam logic [2:0] KW_LE   = 3'd4;
  localparam logic [2:0] KW_LET  = 3'd5;

  // characters
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // lexer mode, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_SYMBOL = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_MINUS  = 6'b001000,
    MODE_HASH   = 6'b010000,
    MODE_BOOLCH = 6'b100000
  } mode_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ttype;
    logic [15:0] line;
    logic [15:0] tstart;
    logic [15:0] tlen;
    logic [2:0]  ecode;
    logic        last;
  } res_t;

  // results written into the queue in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } wr_t;

  // queue status toward the lexer
  typedef struct packed {
    logic [Q_CW-1:0] level;
  } qstat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_symch(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2F) || (c == 8'h2A) || (c == 8'h25) ||
           (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) || (c == CH_MINUS) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_RPAREN);
  endfunction

endpackage

// ===== rtl/lts_in_if.sv =====
// ============================================================================
// lts_in_if
// Input channel: one text byte or an end-of-text mark per word.
// ============================================================================
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] text_byte;

  modport source (output valid, output command, output text_byte, input ready);
  modport sink   (input valid, input command, input text_byte, output ready);
endinterface

// ===== rtl/lts_out_if.sv =====
// ============================================================================
// lts_out_if
// Result channel: one token, error or end-of-text word per transfer.
// ============================================================================
interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  token_type;
  logic [15:0] line_number;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output result_kind, output token_type,
                  output line_number, output token_start, output token_length,
                  output error_code, output last, input ready);
  modport sink   (input valid, input result_kind, input token_type,
                  input line_number, input token_start, input token_length,
                  input error_code, input last, output ready);
endinterface

// ===== rtl/lisp_token_scanner.sv =====
// ============================================================================
// lisp_token_scanner
// Streaming tokenizer, small parenthesized language, a byte a cycle if ready.
// ============================================================================
//
//  port       dir   handshake        moves
//  in_chan    in    valid / ready    text byte or end-of-text mark
//  out_chan   out   valid / ready    token, error or end word
//  apb        in    psel / penable   start line register at byte address 0
//
//  One byte is accepted per cycle while in_chan ready is high; a word reaches
//  out_chan through the input register, then the result queue. A byte that
//  yields two words writes both into the queue together; in_chan ready drops
//  while the eight-entry result queue holds more than four words.
//  Reset is synchronous; no clearing pass is needed.
//
module lisp_token_scanner #(
  parameter int MAX_TEXT = lts_pkg::MAX_TEXT_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lts_in_if.sink                      in_chan,
  lts_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lts_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [15:0]     start_line;
  lts_pkg::wr_t    wr;
  lts_pkg::qstat_t qstat;

  // configuration register
  lts_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_line (start_line)
  );

  // lexer step
  lts_core #(
    .MAX_TEXT (MAX_TEXT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_line (start_line),
    .qstat      (qstat),
    .in_chan    (in_chan),
    .wr         (wr)
  );

  // result queue
  lts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .qstat    (qstat),
    .out_chan (out_chan)
  );

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= lts_pkg::Q_CW'(lts_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // last flag sits on the final word of a byte
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt == 2'd2) |-> (!wr.r0.last && wr.r1.last))
    else $error("last flag wrong on a word pair");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt == 2'd1) |-> wr.r0.last)
    else $error("last flag missing on a single word");

  // words are only written in the cycle after a byte was taken
  a_wr_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt != 2'd0) |-> $past(in_chan.valid && in_chan.ready))
    else $error("result written without an accepted byte");

endmodule

// ===== rtl/lts_cfg.sv =====
// ============================================================================
// lts_cfg
// APB-style register port holding the start line register.
// ============================================================================
module lts_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lts_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [15:0]                 start_line
);

  logic [15:0] start_line_r;
  logic        hit;

  // word decode
  assign hit    = (paddr[lts_pkg::CFG_AW-1] == lts_pkg::REG_START_LINE);
  assign pready = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_line_r <= lts_pkg::START_LINE_RST;
    end else if (psel && penable && pwrite && hit) begin
      start_line_r <= pwdata[15:0];
    end
  end

  // read back
  assign prdata     = hit ? {16'd0, start_line_r} : 32'd0;
  assign start_line = start_line_r;

endmodule

// ===== rtl/lts_core.sv =====
// ============================================================================
// lts_core
// Input register and single-pass lexer step producing up to two results.
// ============================================================================
module lts_core #(
  parameter int MAX_TEXT = lts_pkg::MAX_TEXT_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        start_line,
  input  lts_pkg::qstat_t    qstat,
  lts_in_if.sink             in_chan,
  output lts_pkg::wr_t       wr
);

  localparam int PW = $clog2(MAX_TEXT + 1);

  // input register
  logic       iv_r;
  logic       cmd_r;
  logic [7:0] byte_r;

  // lexer state
  lts_pkg::mode_t mode_r, mode_nxt;
  logic           stop_r, stop_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  soff_r, soff_nxt;
  logic [15:0]    line_r, line_nxt;
  logic [2:0]     kw_r, kw_nxt;

  // step flags
  logic       pend;
  logic       err;
  logic [2:0] err_code;
  logic       idle_call;
  logic       sym_go;
  logic       itok;
  logic [2:0] itok_type;
  logic       endv;
  logic [2:0] pend_type;
  logic       accept;

  lts_pkg::res_t res_p, res_e, res_i, res_end;

  function automatic logic [15:0] sat16(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [2:0] kw_step(input logic [2:0] kw, input logic [7:0] c);
    logic [2:0] r;
    r = lts_pkg::KW_NONE;
    if (kw == lts_pkg::KW_I && c == lts_pkg::CH_LOW_F) r = lts_pkg::KW_IF;
    else if (kw == lts_pkg::KW_L && c == lts_pkg::CH_LOW_E) r = lts_pkg::KW_LE;
    else if (kw == lts_pkg::KW_LE && c == lts_pkg::CH_LOW_T) r = lts_pkg::KW_LET;
    return r;
  endfunction

  // input handshake: queue keeps room for this word and the one in flight
  assign in_chan.ready = (qstat.level <= lts_pkg::Q_CW'(lts_pkg::Q_ACCEPT_MAX));
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_chan.command;
      byte_r <= in_chan.text_byte;
    end
  end

  // type of a pending token
  always_comb begin
    priority if (mode_r == lts_pkg::MODE_NUMBER) pend_type = lts_pkg::TT_INT;
    else if (mode_r == lts_pkg::MODE_BOOLCH)     pend_type = lts_pkg::TT_BOOL;
    else if (kw_r == lts_pkg::KW_IF)             pend_type = lts_pkg::TT_IF;
    else if (kw_r == lts_pkg::KW_LET)            pend_type = lts_pkg::TT_LET;
    else                                         pend_type = lts_pkg::TT_SYMBOL;
  end

  // lexer step
  always_comb begin
    mode_nxt  = mode_r;
    stop_nxt  = stop_r;
    pos_nxt   = pos_r;
    soff_nxt  = soff_r;
    line_nxt  = line_r;
    kw_nxt    = kw_r;
    pend      = 1'b0;
    err       = 1'b0;
    err_code  = lts_pkg::ERR_NONE;
    idle_call = 1'b0;
    sym_go    = 1'b0;
    itok      = 1'b0;
    itok_type = lts_pkg::TT_LPAREN;
    endv      = 1'b0;

    if (iv_r && cmd_r == lts_pkg::CMD_END) begin
      // end of text: flush a pending token or flag an open hash, then the end word
      if (!stop_r) begin
        if (mode_r == lts_pkg::MODE_HASH) begin
          err      = 1'b1;
          err_code = lts_pkg::ERR_EOF_HASH;
        end else if (mode_r != lts_pkg::MODE_IDLE) begin
          pend = 1'b1;
        end
      end
      endv = 1'b1;
    end else if (iv_r && !stop_r) begin
      if (pos_r >= PW'(MAX_TEXT)) begin
        err      = 1'b1;
        err_code = lts_pkg::ERR_TOO_LONG;
      end else begin
        pos_nxt = pos_r + PW'(1);
        unique case (mode_r)
          lts_pkg::MODE_NUMBER: begin
            if (lts_pkg::is_term(byte_r)) begin
              pend      = 1'b1;
              idle_call = 1'b1;
            end else if (!lts_pkg::is_digit(byte_r)) begin
              err      = 1'b1;
              err_code = lts_pkg::ERR_BAD_SYM;
            end
          end
          lts_pkg::MODE_MINUS: begin
            if (lts_pkg::is_digit(byte_r)) begin
              mode_nxt = lts_pkg::MODE_NUMBER;
            end else begin
              kw_nxt = lts_pkg::KW_NONE;
              sym_go = 1'b1;
            end
          end
          lts_pkg::MODE_SYMBOL: sym_go = 1'b1;
          lts_pkg::MODE_HASH: begin
            if (byte_r == lts_pkg::CH_LOW_T || byte_r == lts_pkg::CH_LOW_F) begin
              mode_nxt = lts_pkg::MODE_BOOLCH;
            end else begin
              err      = 1'b1;
              err_code = lts_pkg::ERR_BAD_BOOL;
            end
          end
          lts_pkg::MODE_BOOLCH: begin
            if (lts_pkg::is_term(byte_r)) begin
              pend      = 1'b1;
              idle_call = 1'b1;
            end else begin
              err      = 1'b1;
              err_code = lts_pkg::ERR_BAD_BOOL;
            end
          end
          default: idle_call = 1'b1;
        endcase

        // symbol body, also a minus that starts a symbol
        if (sym_go) begin
          mode_nxt = lts_pkg::MODE_SYMBOL;
          if (lts_pkg::is_term(byte_r)) begin
            pend      = 1'b1;
            idle_call = 1'b1;
          end else if (lts_pkg::is_symch(byte_r) || lts_pkg::is_digit(byte_r)) begin
            kw_nxt = kw_step(kw_nxt, byte_r);
          end else begin
            err      = 1'b1;
            err_code = lts_pkg::ERR_BAD_SYM;
          end
        end

        // character seen outside a token
        if (idle_call) begin
          mode_nxt = lts_pkg::MODE_IDLE;
          soff_nxt = pos_r;
          priority if (byte_r == lts_pkg::CH_NL) begin
            if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          end else if (byte_r == lts_pkg::CH_SPACE || byte_r == lts_pkg::CH_TAB) begin
            mode_nxt = lts_pkg::MODE_IDLE;
          end else if (byte_r == lts_pkg::CH_LPAREN) begin
            itok      = 1'b1;
            itok_type = lts_pkg::TT_LPAREN;
          end else if (byte_r == lts_pkg::CH_RPAREN) begin
            itok      = 1'b1;
            itok_type = lts_pkg::TT_RPAREN;
          end else if (byte_r == lts_pkg::CH_HASH) begin
            mode_nxt = lts_pkg::MODE_HASH;
          end else if (lts_pkg::is_digit(byte_r)) begin
            mode_nxt = lts_pkg::MODE_NUMBER;
          end else if (byte_r == lts_pkg::CH_MINUS) begin
            mode_nxt = lts_pkg::MODE_MINUS;
            kw_nxt   = lts_pkg::KW_NONE;
          end else if (lts_pkg::is_symch(byte_r)) begin
            mode_nxt = lts_pkg::MODE_SYMBOL;
            kw_nxt   = (byte_r == lts_pkg::CH_LOW_I) ? lts_pkg::KW_I :
                       (byte_r == lts_pkg::CH_LOW_L) ? lts_pkg::KW_L : lts_pkg::KW_NONE;
          end else begin
            err      = 1'b1;
            err_code = lts_pkg::ERR_BAD_TOKEN;
          end
        end
      end
    end

    // first error stops the text
    if (err) begin
      stop_nxt = 1'b1;
      mode_nxt = lts_pkg::MODE_IDLE;
    end

    // end of text restores the per-text state
    if (endv) begin
      mode_nxt = lts_pkg::MODE_IDLE;
      stop_nxt = 1'b0;
      pos_nxt  = '0;
      soff_nxt = '0;
      line_nxt = start_line;
      kw_nxt   = lts_pkg::KW_NONE;
    end
  end

  // candidate result words
  always_comb begin
    res_p        = '0;
    res_p.kind   = lts_pkg::RK_TOKEN;
    res_p.ttype  = pend_type;
    res_p.line   = line_r;
    res_p.tstart = sat16(soff_r);
    res_p.tlen   = sat16(pos_r - soff_r);
    res_p.ecode  = lts_pkg::ERR_NONE;

    res_e        = '0;
    res_e.kind   = lts_pkg::RK_ERROR;
    res_e.line   = line_r;
    res_e.ecode  = err_code;

    res_i        = '0;
    res_i.kind   = lts_pkg::RK_TOKEN;
    res_i.ttype  = itok_type;
    res_i.line   = line_r;
    res_i.tstart = sat16(pos_r);
    res_i.tlen   = 16'd1;

    res_end      = '0;
    res_end.kind = lts_pkg::RK_END;
    res_end.line = line_r;
  end

  // order the words for the queue
  always_comb begin
    wr = '0;
    priority if (pend) wr.r0 = res_p;
    else if (err)      wr.r0 = res_e;
    else if (itok)     wr.r0 = res_i;
    else               wr.r0 = res_end;
    wr.r1 = endv ? res_end : res_i;

    if (pend || err) begin
      wr.cnt = (itok || endv) ? 2'd2 : 2'd1;
    end else begin
      wr.cnt = (itok || endv) ? 2'd1 : 2'd0;
    end
    wr.r0.last = (wr.cnt == 2'd1);
    wr.r1.last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lts_pkg::MODE_IDLE;
      stop_r <= 1'b0;
      pos_r  <= '0;
      soff_r <= '0;
      line_r <= lts_pkg::START_LINE_RST;
      kw_r   <= lts_pkg::KW_NONE;
    end else begin
      mode_r <= mode_nxt;
      stop_r <= stop_nxt;
      pos_r  <= pos_nxt;
      soff_r <= soff_nxt;
      line_r <= line_nxt;
      kw_r   <= kw_nxt;
    end
  end

endmodule

// ===== rtl/lts_fifo.sv =====
// ============================================================================
// lts_fifo
// Result queue: takes up to two words a cycle, gives one a cycle when ready.
// ============================================================================
module lts_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  lts_pkg::wr_t     wr,
  output lts_pkg::qstat_t  qstat,
  lts_out_if.source        out_chan
);

  lts_pkg::res_t mem [lts_pkg::Q_DEPTH];

  logic [lts_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [lts_pkg::Q_CW-1:0] level_r;
  logic                     pop;
  lts_pkg::res_t            head;

  assign pop = out_chan.valid && out_chan.ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) mem[wp_r] <= wr.r0;
    if (wr.cnt == 2'd2) mem[wp_r + lts_pkg::Q_AW'(1)] <= wr.r1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_r + lts_pkg::Q_AW'(wr.cnt);
      rp_r    <= rp_r + lts_pkg::Q_AW'(pop);
      level_r <= level_r + lts_pkg::Q_CW'(wr.cnt) - lts_pkg::Q_CW'(pop);
    end
  end

  assign qstat.level = level_r;

  // head word to the port
  assign head                  = mem[rp_r];
  assign out_chan.valid        = (level_r != '0);
  assign out_chan.result_kind  = head.kind;
  assign out_chan.token_type   = head.ttype;
  assign out_chan.line_number  = head.line;
  assign out_chan.token_start  = head.tstart;
  assign out_chan.token_length = head.tlen;
  assign out_chan.error_code   = head.ecode;
  assign out_chan.last         = head.last;

endmodule

// ===== tb/tb_lisp_token_scanner.sv =====
// ============================================================================
// tb_lisp_token_scanner
// Self-checking bench for the token scanner. Text bytes and end-of-text marks
// go in through a stalling source, result words come out through a stalling
// sink, and every result word is checked against a bit-exact software lexer
// that runs alongside. Covers all token kinds, the error codes of short texts,
// start line extremes, line saturation and random well-formed texts with
// noise mixed in.
// ============================================================================
module tb_lisp_token_scanner;
  import lts_pkg::*;

  localparam int TEXT_LIMIT   = MAX_TEXT_DFLT;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_WORDS = 2000;
  localparam int CALM_WORDS   = 400;
  localparam int MAX_REPORTS  = 10;

  // token type field carried by error and end words
  localparam logic [2:0]        TT_NONE         = 3'd0;
  localparam logic [CFG_AW-1:0] START_LINE_ADDR = {REG_START_LINE, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lts_in_if  in_ch();
  lts_out_if out_ch();

  lisp_token_scanner #(.MAX_TEXT(TEXT_LIMIT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // lexer shadow state
  logic [15:0] line_origin;
  mode_t       scan_mode;
  bit          halted;
  int unsigned scan_pos;
  int unsigned tok_origin;
  logic [15:0] line_now;
  logic [2:0]  kw_state;

  res_t        due_tokens[$];
  res_t        step_words[$];
  logic [7:0]  draft[$];
  string       name_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+/*%=<>-";

  bit          calm;
  int unsigned words_sent;
  int unsigned live_words;
  int unsigned words_checked;
  int unsigned texts_sent;
  int unsigned mismatches;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("run limit of %0d cycles reached", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // character classes
  function automatic bit digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit name_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "+") || (c == "/") || (c == "*") || (c == "%") ||
           (c == "=") || (c == "<") || (c == ">") || (c == CH_MINUS);
  endfunction

  function automatic bit ends_token(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_RPAREN);
  endfunction

  function automatic logic [15:0] clip16(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // result word bookkeeping for the current input word
  function automatic void note_word(input logic [1:0] kind, input logic [2:0] ttype,
                                    input int unsigned first, input int unsigned len,
                                    input logic [2:0] ecode);
    res_t w;
    w.kind   = kind;
    w.ttype  = ttype;
    w.line   = line_now;
    w.tstart = clip16(first);
    w.tlen   = clip16(len);
    w.ecode  = ecode;
    w.last   = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void flag_error(input logic [2:0] ecode);
    note_word(RK_ERROR, TT_NONE, 0, 0, ecode);
    halted    = 1'b1;
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void close_token();
    logic [2:0] ttype;
    ttype = TT_SYMBOL;
    if (scan_mode == MODE_NUMBER) ttype = TT_INT;
    else if (scan_mode == MODE_BOOLCH) ttype = TT_BOOL;
    else if (kw_state == KW_IF) ttype = TT_IF;
    else if (kw_state == KW_LET) ttype = TT_LET;
    note_word(RK_TOKEN, ttype, tok_origin, scan_pos - tok_origin, ERR_NONE);
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void kw_advance(input logic [7:0] c);
    if (kw_state == KW_I && c == CH_LOW_F) kw_state = KW_IF;
    else if (kw_state == KW_L && c == CH_LOW_E) kw_state = KW_LE;
    else if (kw_state == KW_LE && c == CH_LOW_T) kw_state = KW_LET;
    else kw_state = KW_NONE;
  endfunction

  function automatic void begin_text();
    scan_mode  = MODE_IDLE;
    halted     = 1'b0;
    scan_pos   = 0;
    tok_origin = 0;
    line_now   = line_origin;
    kw_state   = KW_NONE;
  endfunction

  // byte seen between tokens
  function automatic void start_char(input logic [7:0] c);
    tok_origin = scan_pos;
    if (c == CH_NL) begin
      if (line_now != 16'hFFFF) line_now = line_now + 16'd1;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      // plain whitespace, nothing to do
    end else if (c == CH_LPAREN) begin
      note_word(RK_TOKEN, TT_LPAREN, scan_pos, 1, ERR_NONE);
    end else if (c == CH_RPAREN) begin
      note_word(RK_TOKEN, TT_RPAREN, scan_pos, 1, ERR_NONE);
    end else if (c == CH_HASH) begin
      scan_mode = MODE_HASH;
    end else if (digit_char(c)) begin
      scan_mode = MODE_NUMBER;
    end else if (c == CH_MINUS) begin
      scan_mode = MODE_MINUS;
      kw_state  = KW_NONE;
    end else if (name_char(c)) begin
      scan_mode = MODE_SYMBOL;
      kw_state  = (c == CH_LOW_I) ? KW_I : (c == CH_LOW_L) ? KW_L : KW_NONE;
    end else begin
      flag_error(ERR_BAD_TOKEN);
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (scan_mode)
      MODE_NUMBER: begin
        if (ends_token(c)) begin
          close_token();
          start_char(c);
        end else if (!digit_char(c)) begin
          flag_error(ERR_BAD_SYM);
        end
      end
      MODE_MINUS, MODE_SYMBOL: begin
        if (scan_mode == MODE_MINUS && digit_char(c)) begin
          scan_mode = MODE_NUMBER;
        end else begin
          // a minus without a digit after it starts a symbol
          if (scan_mode == MODE_MINUS) kw_state = KW_NONE;
          scan_mode = MODE_SYMBOL;
          if (ends_token(c)) begin
            close_token();
            start_char(c);
          end else if (name_char(c) || digit_char(c)) begin
            kw_advance(c);
          end else begin
            flag_error(ERR_BAD_SYM);
          end
        end
      end
      MODE_HASH: begin
        if (c == CH_LOW_T || c == CH_LOW_F) scan_mode = MODE_BOOLCH;
        else flag_error(ERR_BAD_BOOL);
      end
      MODE_BOOLCH: begin
        if (ends_token(c)) begin
          close_token();
          start_char(c);
        end else begin
          flag_error(ERR_BAD_BOOL);
        end
      end
      default: begin
        scan_mode = MODE_IDLE;
        start_char(c);
      end
    endcase
  endfunction

  // expected result words for one accepted input word
  function automatic void predict_word(input logic cmd, input logic [7:0] c);
    res_t tail;
    step_words.delete();
    if (cmd == CMD_END) begin
      if (!halted) begin
        if (scan_mode == MODE_HASH) flag_error(ERR_EOF_HASH);
        else if (scan_mode != MODE_IDLE) close_token();
      end
      note_word(RK_END, TT_NONE, 0, 0, ERR_NONE);
      begin_text();
    end else if (!halted) begin
      if (scan_pos >= TEXT_LIMIT) begin
        flag_error(ERR_TOO_LONG);
      end else begin
        scan_char(c);
        scan_pos++;
      end
    end
    if (step_words.size() > 0) begin
      tail = step_words.pop_back();
      tail.last = 1'b1;
      step_words.insert(step_words.size(), tail);
    end
    foreach (step_words[i]) due_tokens.insert(due_tokens.size(), step_words[i]);
  endfunction

  function automatic void show_word(input string tag, input res_t w);
    $display("%s kind=%0d type=%0d line=%0d start=%0d len=%0d err=%0d last=%0b",
             tag, w.kind, w.ttype, w.line, w.tstart, w.tlen, w.ecode, w.last);
  endfunction

  // compare one accepted result word with the oldest expected one
  function automatic void check_word();
    res_t got;
    res_t want;
    got.kind   = out_ch.result_kind;
    got.ttype  = out_ch.token_type;
    got.line   = out_ch.line_number;
    got.tstart = out_ch.token_start;
    got.tlen   = out_ch.token_length;
    got.ecode  = out_ch.error_code;
    got.last   = out_ch.last;
    words_checked++;
    if (due_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: result word %0d arrived with nothing expected", $time, words_checked);
        show_word("  actual  ", got);
      end
    end else begin
      want = due_tokens.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result word %0d differs", $time, words_checked);
          show_word("  expected", want);
          show_word("  actual  ", got);
        end
      end
    end
  endfunction

  // result sink with random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) check_word();
        out_ch.ready <= calm || ($urandom_range(99) >= 25);
      end
    end
  end

  // one input word through the valid/ready handshake
  task automatic send_word(input logic cmd, input logic [7:0] c);
    if (!calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.text_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_END || !halted) live_words++;
    predict_word(cmd, c);
    words_sent++;
  endtask

  // hold off input until every expected word is back and the pipe is empty
  task automatic await_idle();
    in_ch.valid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start_line(input logic [15:0] value);
    await_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_LINE_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    line_origin = value;
  endtask

  function automatic logic [15:0] pick_line();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // send the drafted text and its end mark, optionally rewriting the
  // start line register partway through
  task automatic send_text(input int split_at);
    foreach (draft[i]) begin
      if (i == split_at) set_start_line(pick_line());
      send_word(CMD_CHAR, draft[i]);
    end
    send_word(CMD_END, 8'($urandom_range(255)));
    texts_sent++;
  endtask

  // text building
  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) draft.insert(draft.size(), s[i]);
  endfunction

  function automatic void put_gap();
    case ($urandom_range(19))
      0: ;  // no separator, the next token runs into this one
      1, 2, 3: draft.insert(draft.size(), CH_RPAREN);
      4, 5, 6: draft.insert(draft.size(), CH_NL);
      7, 8: draft.insert(draft.size(), CH_TAB);
      default: draft.insert(draft.size(), CH_SPACE);
    endcase
  endfunction

  function automatic void put_name();
    int unsigned n;
    draft.insert(draft.size(), name_pool[$urandom_range(name_pool.len() - 1)]);
    n = $urandom_range(6);
    repeat (n) begin
      if ($urandom_range(3) == 0) draft.insert(draft.size(), 8'("0" + $urandom_range(9)));
      else draft.insert(draft.size(), name_pool[$urandom_range(name_pool.len() - 1)]);
    end
  endfunction

  function automatic void put_keyish();
    case ($urandom_range(8))
      0, 1: put_str("if");
      2, 3: put_str("let");
      4: put_str("i");
      5: put_str("le");
      6: put_str("iff");
      7: put_str("lets");
      default: put_str("-");
    endcase
  endfunction

  function automatic void put_token();
    int unsigned n;
    case ($urandom_range(9))
      0: draft.insert(draft.size(), CH_LPAREN);
      1: draft.insert(draft.size(), CH_RPAREN);
      2, 3: begin
        if ($urandom_range(2) == 0) draft.insert(draft.size(), CH_MINUS);
        n = $urandom_range(1, 5);
        repeat (n) draft.insert(draft.size(), 8'("0" + $urandom_range(9)));
        put_gap();
      end
      4: begin
        draft.insert(draft.size(), CH_HASH);
        draft.insert(draft.size(), $urandom_range(1) ? CH_LOW_T : CH_LOW_F);
        put_gap();
      end
      5, 6: begin
        put_name();
        put_gap();
      end
      default: begin
        put_keyish();
        put_gap();
      end
    endcase
  endfunction

  // every token kind, keywords, lone minus, newline as terminator
  task automatic test_token_kinds();
    draft.delete();
    put_str("(if -7 #t)");
    send_text(-1);
    draft.delete();
    put_str("let - -x\t42\n");
    send_text(-1);
  endtask

  // error codes of short texts, bytes ignored after an error
  task automatic test_errors();
    draft.delete();
    put_str("#");
    send_text(-1);
    draft.delete();
    put_str("5a(");
    send_text(-1);
    draft.delete();
    put_str("#q");
    send_text(-1);
    draft.delete();
    put_str("#fx");
    send_text(-1);
    draft.delete();
    put_str("a!");
    send_text(-1);
    draft.delete();
    draft.insert(draft.size(), 8'hFF);
    send_text(-1);
  endtask

  // start line extremes and line saturation
  task automatic test_line_limits();
    set_start_line(16'hFFFF);
    draft.delete();
    put_str("a\nb");
    send_text(-1);
    set_start_line(16'h0000);
    draft.delete();
    put_str("\n)");
    send_text(-1);
  endtask

  // random well-formed texts with noise, broken endings and register writes
  task automatic test_random_texts();
    int          split_at;
    int unsigned tokens;
    int unsigned goal;
    int unsigned calm_until;
    bit          paused;
    goal       = live_words + RANDOM_WORDS;
    calm_until = live_words + CALM_WORDS;
    paused     = 1'b0;
    while (live_words < goal) begin
      calm = (live_words < calm_until);
      draft.delete();
      tokens = $urandom_range(12);
      repeat (tokens) begin
        put_token();
        if ($urandom_range(99) < 3) draft.insert(draft.size(), 8'($urandom_range(255)));
      end
      if ($urandom_range(19) == 0) draft.insert(draft.size(), CH_HASH);
      split_at = -1;
      if (draft.size() > 0 && $urandom_range(11) == 0) begin
        split_at = $urandom_range(draft.size() - 1);
      end
      send_text(split_at);
      if ($urandom_range(11) == 0) set_start_line(pick_line());
      // sender holds off once until everything has drained
      if (!paused && live_words + RANDOM_WORDS / 2 >= goal) begin
        await_idle();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned spin;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_CHAR;
    in_ch.text_byte <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    calm          = 1'b0;
    words_sent    = 0;
    live_words    = 0;
    words_checked = 0;
    texts_sent    = 0;
    mismatches    = 0;
    line_origin   = START_LINE_RST;
    begin_text();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_token_kinds();
    test_errors();
    test_line_limits();
    test_random_texts();

    // drain, bounded
    in_ch.valid <= 1'b0;
    spin = 0;
    while (due_tokens.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (SETTLE) @(posedge clk);
    if (due_tokens.size() != 0) begin
      $display("%0d expected result words never arrived", due_tokens.size());
      mismatches += due_tokens.size();
    end

    $display("%0d texts, %0d input words, %0d result words checked, %0d failures",
             texts_sent, words_sent, words_checked, mismatches);
    $display("all token kinds, short-text error codes, start line extremes, line saturation");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== lisp_token_scanner.f =====
rtl/lts_pkg.sv
rtl/lts_in_if.sv
rtl/lts_out_if.sv
rtl/lts_cfg.sv
rtl/lts_core.sv
rtl/lts_fifo.sv
rtl/lisp_token_scanner.sv
tb/tb_lisp_token_scanner.sv
